/* rtl/matrix_structure_classifier_defines.svh */
// assertion macros for the matrix structure classifier
// no dependencies; included by files that carry concurrent checks

`ifndef MATRIX_STRUCTURE_CLASSIFIER_DEFINES_SVH
`define MATRIX_STRUCTURE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checks off while in reset
`define MSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("msc same-cycle check failed");

// next-cycle implication, checks off while in reset
`define MSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("msc next-cycle check failed");

`endif

/* rtl/msc_pkg.sv */
// shared types and constants for the matrix structure classifier
// no dependencies; imported by msc_flags, the top level and the bench

package msc_pkg;

  // port widths fixed by the word formats
  localparam int IN_BITS   = 32;
  localparam int CFG_BITS  = 6;
  localparam int NUM_FLAGS = 11;
  localparam int OUT_BITS  = 16;

  // bit positions of the structure flags in the result word
  localparam int F_IDENTITY = 0;
  localparam int F_NULL     = 1;
  localparam int F_DIAGONAL = 2;
  localparam int F_ANTIDIAG = 3;
  localparam int F_UPPER    = 4;
  localparam int F_LOWER    = 5;
  localparam int F_SYMM     = 6;
  localparam int F_ANTISYMM = 7;
  localparam int F_ECHELON  = 8;
  localparam int F_HANKEL   = 9;
  localparam int F_TOEPLITZ = 10;

  // flags that still apply to a non-square matrix
  localparam logic [NUM_FLAGS-1:0] RECT_MASK =
    NUM_FLAGS'((1 << F_NULL) | (1 << F_ECHELON));

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

  // position of one element within the matrix, decoded at accept time
  typedef struct packed {
    logic square;
    logic diag;
    logic below;
    logic above;
    logic anti;
    logic hank_chk;
    logic toep_chk;
    logic row_end;
    logic last;
  } msc_pos_t;

endpackage

/* rtl/msc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies

module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/msc_hist.sv */
// delay line of recent elements for the hankel and toeplitz compares
// depends on nothing but its parameters; length follows the column count

module msc_hist #(
  parameter int MAX_DIM   = 32,
  parameter int ELEM_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             push_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     len_i,
  input  logic [ELEM_BITS-1:0]             din_i,
  output logic [ELEM_BITS-1:0]             near_o,
  output logic [ELEM_BITS-1:0]             far_o
);

  localparam int DEPTH = MAX_DIM + 1;
  localparam int LW    = $clog2(MAX_DIM + 1);

  logic [ELEM_BITS-1:0] line_q [DEPTH];

  // new word enters at position len and walks down to position 0, so
  // position 0 holds the word len+1 back and position 2 the word len-1 back
  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    if (k == DEPTH - 1) begin : g_top
      always_ff @(posedge clk_i) begin
        if (push_i) begin
          line_q[k] <= din_i;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk_i) begin
        if (push_i) begin
          line_q[k] <= (len_i == LW'(k)) ? din_i : line_q[k+1];
        end
      end
    end
  end

  assign near_o = line_q[2];
  assign far_o  = line_q[0];

endmodule

/* rtl/msc_flags.sv */
// running pass flags and row echelon tracking for the classifier
// depends on msc_pkg

module msc_flags #(
  parameter int MAX_DIM   = 32,
  parameter int ELEM_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           restart_i,
  input  logic                           adv_i,
  input  msc_pkg::msc_pos_t              pos_i,
  input  logic [$clog2(MAX_DIM)-1:0]     col_i,
  input  logic [ELEM_BITS-1:0]           elem_i,
  input  logic [ELEM_BITS-1:0]           sym_ref_i,
  input  logic [ELEM_BITS-1:0]           hank_ref_i,
  input  logic [ELEM_BITS-1:0]           toep_ref_i,
  output logic [msc_pkg::NUM_FLAGS-1:0]  result_o
);

  import msc_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);

  logic [NUM_FLAGS-1:0] pass_q, pass_d, pass_next, fail;
  logic                 row_nz_q, row_nz_d;
  logic                 piv_vld_q, piv_vld_d;
  logic [IDX_W-1:0]     piv_q, piv_d;
  logic                 nz, is_one, new_lead;
  logic [ELEM_BITS-1:0] sym_t, neg_e;

  // per-element compares
  always_comb begin
    nz       = (elem_i != '0);
    is_one   = (elem_i == ELEM_BITS'(1));
    neg_e    = '0 - elem_i;
    sym_t    = pos_i.diag ? elem_i : sym_ref_i;
    new_lead = nz && !row_nz_q;

    fail             = '0;
    fail[F_NULL]     = nz;
    fail[F_ECHELON]  = new_lead && piv_vld_q && (col_i <= piv_q);
    if (pos_i.square) begin
      fail[F_IDENTITY] = pos_i.diag ? !is_one : nz;
      fail[F_DIAGONAL] = !pos_i.diag && nz;
      fail[F_ANTIDIAG] = !pos_i.anti && nz;
      fail[F_UPPER]    = pos_i.below && nz;
      fail[F_LOWER]    = pos_i.above && nz;
      fail[F_SYMM]     = (pos_i.diag || pos_i.below) && (sym_t != elem_i);
      fail[F_ANTISYMM] = (pos_i.diag || pos_i.below) && (sym_t != neg_e);
      fail[F_HANKEL]   = pos_i.hank_chk && (elem_i != hank_ref_i);
      fail[F_TOEPLITZ] = pos_i.toep_chk && (elem_i != toep_ref_i);
    end

    pass_next = pass_q & ~fail;
    result_o  = pos_i.square ? pass_next : (pass_next & RECT_MASK);
  end

  // next state of the running flags and row tracking
  always_comb begin
    pass_d    = pass_q;
    row_nz_d  = row_nz_q;
    piv_vld_d = piv_vld_q;
    piv_d     = piv_q;
    if (restart_i) begin
      pass_d    = '1;
      row_nz_d  = 1'b0;
      piv_vld_d = 1'b0;
      piv_d     = '0;
    end else if (adv_i) begin
      if (pos_i.last) begin
        pass_d    = '1;
        row_nz_d  = 1'b0;
        piv_vld_d = 1'b0;
        piv_d     = '0;
      end else begin
        pass_d   = pass_next;
        row_nz_d = pos_i.row_end ? 1'b0 : (row_nz_q || nz);
        if (new_lead) begin
          piv_vld_d = 1'b1;
          piv_d     = col_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q    <= '1;
      row_nz_q  <= 1'b0;
      piv_vld_q <= 1'b0;
      piv_q     <= '0;
    end else begin
      pass_q    <= pass_d;
      row_nz_q  <= row_nz_d;
      piv_vld_q <= piv_vld_d;
      piv_q     <= piv_d;
    end
  end

endmodule

/* rtl/matrix_structure_classifier.sv */
// matrix structure classifier: one element word accepted per cycle, row-major
// result word: the last element passes the first stage register, then the result word register
// throughput: one element per cycle, set by one ram write and one ram read
// per element; stalls only while the last element waits on a full output
// reset: rows and columns 32 (or MAX_DIM if smaller), counters at the first
// element, all pass flags set; the element store holds no reset value
`include "matrix_structure_classifier_defines.svh"

module matrix_structure_classifier #(
  parameter int MAX_DIM   = 32,
  parameter int ELEM_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic                           cfg_addr_i,
  input  logic [msc_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  // element words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [msc_pkg::IN_BITS-1:0]    s_axis_tdata,  // [31:0] element
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] is_identity, [1] is_null, [2] is_diagonal, [3] is_antidiagonal,
  // [4] is_upper_triangular, [5] is_lower_triangular, [6] is_symmetric,
  // [7] is_antisymmetric, [8] is_row_echelon, [9] is_hankel,
  // [10] is_toeplitz, [15:11] zero
  output logic [msc_pkg::OUT_BITS-1:0]   m_axis_tdata
);

  import msc_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int SUM_W = DIM_W + 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(MAX_DIM < 32 ? MAX_DIM : 32);

  // clamp a written dimension into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  logic [DIM_W-1:0]     rows_q, cols_q;
  logic [IDX_W-1:0]     row_q, row_d, col_q, col_d;
  logic                 in_acc, s1_adv, restart;
  logic [ELEM_BITS-1:0] elem_in;
  msc_pos_t             pos;
  logic [AW-1:0]        waddr, raddr;
  logic [ELEM_BITS-1:0] near_tap, far_tap, sym_ref;

  logic                 s1_vld_q;
  msc_pos_t             s1_pos_q;
  logic [IDX_W-1:0]     s1_col_q;
  logic [ELEM_BITS-1:0] s1_elem_q, s1_hank_q, s1_toep_q;

  logic                 out_vld_q;
  logic [NUM_FLAGS-1:0] out_flags_q, result;

  // handshake: the first stage moves unless its last element meets a full output
  assign s1_adv        = s1_vld_q && (!s1_pos_q.last || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign restart       = cfg_we_i;

  assign elem_in = ELEM_BITS'($signed(s_axis_tdata[IN_BITS-1:0]));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RST;
      cols_q <= DIM_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_ROWS: rows_q <= clamp_dim(cfg_wdata_i);
        REG_COLS: cols_q <= clamp_dim(cfg_wdata_i);
        default:  rows_q <= rows_q;
      endcase
    end
  end

  // position decode of the incoming element
  always_comb begin
    pos.square   = (rows_q == cols_q);
    pos.diag     = (row_q == col_q);
    pos.below    = (row_q > col_q);
    pos.above    = (row_q < col_q);
    pos.anti     = (SUM_W'(row_q) + SUM_W'(col_q)) == SUM_W'(rows_q - DIM_W'(1));
    pos.row_end  = (DIM_W'(col_q) == cols_q - DIM_W'(1));
    pos.last     = pos.row_end && (DIM_W'(row_q) == rows_q - DIM_W'(1));
    pos.hank_chk = (row_q != '0) && !pos.row_end;
    pos.toep_chk = (row_q != '0) && (col_q != '0);
  end

  // row and column counters
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart) begin
      row_d = '0;
      col_d = '0;
    end else if (in_acc) begin
      if (pos.row_end) begin
        col_d = '0;
        row_d = pos.last ? '0 : row_q + IDX_W'(1);
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // element store: write at (row, col), read the mirrored entry (col, row)
  assign waddr = AW'(row_q) * AW'(MAX_DIM) + AW'(col_q);
  assign raddr = AW'(col_q) * AW'(MAX_DIM) + AW'(row_q);

  msc_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (waddr),
    .wdata_i (elem_in),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (sym_ref)
  );

  // previous-row taps
  msc_hist #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_hist (
    .clk_i  (clk_i),
    .push_i (in_acc),
    .len_i  (cols_q),
    .din_i  (elem_in),
    .near_o (near_tap),
    .far_o  (far_tap)
  );

  // first stage register, aligned with the store read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q  <= pos;
      s1_col_q  <= col_q;
      s1_elem_q <= elem_in;
      s1_hank_q <= near_tap;
      s1_toep_q <= far_tap;
    end
  end

  msc_flags #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_flags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .adv_i      (s1_adv),
    .pos_i      (s1_pos_q),
    .col_i      (s1_col_q),
    .elem_i     (s1_elem_q),
    .sym_ref_i  (sym_ref),
    .hank_ref_i (s1_hank_q),
    .toep_ref_i (s1_toep_q),
    .result_o   (result)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv && s1_pos_q.last) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pos_q.last) begin
      out_flags_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_BITS'(out_flags_q);

  // checks
  `MSC_ASSERT_IMP(a_stall_on_full, clk_i, rst_ni,
    s1_vld_q && s1_pos_q.last && out_vld_q && !m_axis_tready, !s_axis_tready)
  `MSC_ASSERT_IMP(a_col_in_range, clk_i, rst_ni, 1'b1, DIM_W'(col_q) < cols_q)
  `MSC_ASSERT_NXT(a_last_gives_word, clk_i, rst_ni, s1_adv && s1_pos_q.last, out_vld_q)
  `MSC_ASSERT_NXT(a_cfg_restarts, clk_i, rst_ni, cfg_we_i, row_q == '0 && col_q == '0)

endmodule

/* tb/tb_matrix_structure_classifier.sv */
// self-checking bench for matrix_structure_classifier: streams matrices in row-major
// order, predicts the eleven structure flags and checks every result word
// depends on msc_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_matrix_structure_classifier;
  import msc_pkg::*;

  localparam int DIM      = 32;
  localparam int HALF_PER = 10;

  // register settings per phase, extremes and out-of-range codes included
  localparam logic [CFG_BITS-1:0] PHASE_ROWS [16] =
    '{2, 3, 63, 4, 1, 5, 3, 32, 6, 0, 4, 8, 2, 7, 3, 1};
  localparam logic [CFG_BITS-1:0] PHASE_COLS [16] =
    '{2, 3, 2, 4, 32, 5, 5, 1, 6, 4, 3, 8, 33, 7, 2, 1};

  typedef enum int {
    SH_RANDOM, SH_NULL, SH_IDENTITY, SH_DIAG, SH_ANTIDIAG, SH_UPPER, SH_LOWER,
    SH_SYMM, SH_ANTISYMM, SH_ECHELON, SH_HANKEL, SH_TOEPLITZ, SH_TINY, SH_COUNT
  } shape_e;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic                  cfg_addr_i    = 1'b0;
  logic [CFG_BITS-1:0]   cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_BITS-1:0]    s_axis_tdata  = '0;   // [31:0] element
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]   m_axis_tdata;         // [10:0] structure flags, [15:11] zero

  matrix_structure_classifier dut (.*);

  always #HALF_PER clk_i = ~clk_i;

  string flag_name [NUM_FLAGS] = '{"is_identity", "is_null", "is_diagonal",
    "is_antidiagonal", "is_upper_triangular", "is_lower_triangular", "is_symmetric",
    "is_antisymmetric", "is_row_echelon", "is_hankel", "is_toeplitz"};

  // stimulus and scoreboard
  logic [IN_BITS-1:0]   elem_queue [$];
  logic [NUM_FLAGS-1:0] expected_flags [$];
  logic [NUM_FLAGS-1:0] want_flags;
  logic [IN_BITS-1:0]   grid [DIM][DIM];
  idle_e                idle_mode  = IDLE_NONE;
  bit                   elem_taken = 1'b0;
  int                   error_count = 0;
  int                   elems_in = 0;
  int                   results_seen = 0;
  int                   phase_items, dim_r, dim_c;
  bit                   first_matrix;

  // classifier state as the block should hold it
  logic [IN_BITS-1:0]   seen_elems [DIM*DIM];
  logic [CFG_BITS-1:0]  rows_cfg = 6'd32;
  logic [CFG_BITS-1:0]  cols_cfg = 6'd32;
  int                   cur_row = 0;
  int                   cur_col = 0;
  logic [NUM_FLAGS-1:0] live_flags = '1;
  int                   pivot_col = -1;
  bit                   row_nz = 1'b0;

  function automatic int clamp_dim(input logic [CFG_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic int idle_pct(input bit sender_side);
    case (idle_mode)
      IDLE_SEND: return sender_side ? 88 : 0;
      IDLE_RECV: return sender_side ? 0 : 88;
      IDLE_BOTH: return 12;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [IN_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hffff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      5:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_BITS-1:0] nonzero_value();
    logic [IN_BITS-1:0] v;
    v = pick_value();
    return (v == 0) ? 32'd1 : v;
  endfunction

  task automatic log_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic clear_tally();
    cur_row    = 0;
    cur_col    = 0;
    live_flags = '1;
    pivot_col  = -1;
    row_nz     = 1'b0;
  endtask

  // fold one accepted element into the running flags
  task automatic classify_element(input logic [IN_BITS-1:0] e);
    int n, m, i, j;
    bit square, nz;
    logic [IN_BITS-1:0] t;
    n = clamp_dim(rows_cfg);
    m = clamp_dim(cols_cfg);
    square = (n == m);
    i = cur_row;
    j = cur_col;
    nz = (e != 0);
    seen_elems[i*DIM + j] = e;
    if (nz) live_flags[F_NULL] = 1'b0;
    if (square) begin
      if (i == j ? (e != 32'd1) : nz) live_flags[F_IDENTITY] = 1'b0;
      if (i != j && nz) live_flags[F_DIAGONAL] = 1'b0;
      if (i + j != n - 1 && nz) live_flags[F_ANTIDIAG] = 1'b0;
      if (i > j && nz) live_flags[F_UPPER] = 1'b0;
      if (i < j && nz) live_flags[F_LOWER] = 1'b0;
      // mirror entry is already stored once we are on or below the diagonal
      if (j <= i) begin
        t = seen_elems[j*DIM + i];
        if (t != e) live_flags[F_SYMM] = 1'b0;
        if (t != ~e + 32'd1) live_flags[F_ANTISYMM] = 1'b0;
      end
      if (i >= 1 && j + 1 < m && e != seen_elems[(i-1)*DIM + j + 1])
        live_flags[F_HANKEL] = 1'b0;
      if (i >= 1 && j >= 1 && e != seen_elems[(i-1)*DIM + j - 1])
        live_flags[F_TOEPLITZ] = 1'b0;
    end
    // leading nonzero of this row against the previous pivot
    if (nz && !row_nz) begin
      row_nz = 1'b1;
      if (j <= pivot_col) live_flags[F_ECHELON] = 1'b0;
      pivot_col = j;
    end
    if (j + 1 < m) begin
      cur_col = j + 1;
    end else begin
      cur_col = 0;
      row_nz  = 1'b0;
      if (i + 1 < n) begin
        cur_row = i + 1;
      end else begin
        expected_flags.push_back(square ? live_flags : (live_flags & RECT_MASK));
        clear_tally();
      end
    end
  endtask

  // register write, also restarts the matrix in progress
  task automatic write_register(input reg_idx_e idx, input logic [CFG_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    if (idx == REG_ROWS) rows_cfg = value;
    else cols_cfg = value;
    clear_tally();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // everything sent, every result back, then the pipeline latency
  task automatic wait_idle();
    while (elem_queue.size() != 0 || s_axis_tvalid || expected_flags.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // build one n x m matrix of the given shape and queue it row-major
  task automatic queue_matrix(input int n, input int m, input shape_e shape);
    logic [IN_BITS-1:0] seq [2*DIM];
    int pivot, row_lead;
    for (int k = 0; k < 2*DIM; k++) seq[k] = pick_value();
    pivot = -1;
    row_lead = 0;
    for (int r = 0; r < n; r++) begin
      // echelon rows: zero rows anywhere, else a pivot right of the last one
      if (shape == SH_ECHELON) begin
        if ($urandom_range(0, 4) == 0) begin
          row_lead = m;
        end else begin
          row_lead = pivot + 1 + $urandom_range(0, 2);
          if (row_lead < m) pivot = row_lead;
        end
      end
      for (int c = 0; c < m; c++) begin
        case (shape)
          SH_NULL:     grid[r][c] = '0;
          SH_IDENTITY: grid[r][c] = (r == c) ? 32'd1 : 32'd0;
          SH_DIAG:     grid[r][c] = (r == c) ? pick_value() : 32'd0;
          SH_ANTIDIAG: grid[r][c] = (r + c == n - 1) ? pick_value() : 32'd0;
          SH_UPPER:    grid[r][c] = (r <= c) ? pick_value() : 32'd0;
          SH_LOWER:    grid[r][c] = (r >= c) ? pick_value() : 32'd0;
          SH_SYMM:     grid[r][c] = (r > c && r < m) ? grid[c][r] : pick_value();
          SH_ANTISYMM: begin
            if (r > c && r < m) grid[r][c] = ~grid[c][r] + 32'd1;
            else if (r == c) grid[r][c] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
            else grid[r][c] = pick_value();
          end
          SH_ECHELON:  grid[r][c] = (c < row_lead) ? 32'd0 :
                                    (c == row_lead) ? nonzero_value() : pick_value();
          SH_HANKEL:   grid[r][c] = seq[r + c];
          SH_TOEPLITZ: grid[r][c] = seq[r - c + m - 1];
          SH_TINY:     grid[r][c] = $urandom_range(0, 2) - 1;
          default:     grid[r][c] = pick_value();
        endcase
      end
    end
    // now and then one entry is disturbed so a flag may drop
    if ($urandom_range(0, 3) == 0)
      grid[$urandom_range(0, n-1)][$urandom_range(0, m-1)] = pick_value();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < m; c++)
        elem_queue.push_back(grid[r][c]);
  endtask

  // element driver and result ready, both moved on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || elem_taken) begin
        if (elem_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= elem_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // monitor: predict on accepted elements, compare accepted result words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      elem_taken = s_axis_tvalid && s_axis_tready;
      if (elem_taken) begin
        classify_element(s_axis_tdata);
        elems_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_flags.size() == 0) begin
          log_failure($sformatf("result word %h with no matrix pending", m_axis_tdata));
        end else begin
          want_flags = expected_flags.pop_front();
          for (int k = 0; k < NUM_FLAGS; k++)
            if (m_axis_tdata[k] !== want_flags[k])
              log_failure($sformatf("result %0d %s: expected %b, got %b",
                                    results_seen, flag_name[k], want_flags[k],
                                    m_axis_tdata[k]));
          if (m_axis_tdata[OUT_BITS-1:NUM_FLAGS] !== '0)
            log_failure($sformatf("result %0d pad bits: expected 0, got %b", results_seen,
                                  m_axis_tdata[OUT_BITS-1:NUM_FLAGS]));
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero codes act as 1x1: corner values of a single element
    write_register(REG_ROWS, 6'd0);
    write_register(REG_COLS, 6'd0);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd1);
    elem_queue.push_back(32'h8000_0000);
    elem_queue.push_back(32'h7fff_ffff);
    elem_queue.push_back(32'hffff_ffff);
    wait_idle();

    // 2x2 antisymmetric, then most negative value against its own negation
    write_register(REG_ROWS, 6'd2);
    write_register(REG_COLS, 6'd2);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd5);
    elem_queue.push_back(32'hffff_fffb);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'h8000_0000);
    elem_queue.push_back(32'h8000_0000);
    elem_queue.push_back(32'h8000_0000);
    wait_idle();

    // 2x3: leading zero row keeps echelon, then a partial matrix cut by a write
    write_register(REG_COLS, 6'd3);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd0);
    elem_queue.push_back(32'd7);
    elem_queue.push_back(32'd1);
    elem_queue.push_back(32'd2);
    elem_queue.push_back(32'd3);
    wait_idle();

    // random phases, one register setting and one idle mix each
    for (int p = 0; p < 16; p++) begin
      idle_mode = idle_e'(p % 4);
      write_register(REG_ROWS, PHASE_ROWS[p]);
      write_register(REG_COLS, PHASE_COLS[p]);
      dim_r = clamp_dim(PHASE_ROWS[p]);
      dim_c = clamp_dim(PHASE_COLS[p]);
      phase_items = 0;
      first_matrix = 1'b1;
      while (phase_items < 45) begin
        queue_matrix(dim_r, dim_c, shape_e'($urandom_range(0, int'(SH_COUNT) - 1)));
        phase_items += dim_r * dim_c;
        // sender holds off until the block has drained
        if (first_matrix && p % 8 == 1) wait_idle();
        first_matrix = 1'b0;
      end
      wait_idle();
    end

    if (expected_flags.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_flags.size()));
    $display("covered %0d elements and %0d result words over 19 register settings,",
             elems_in, results_seen);
    $display("structured and disturbed matrices under four idle and stall mixes");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout: %0d elements queued, %0d results pending", elem_queue.size(),
             expected_flags.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
